>>> design/i2cw_pkg.sv
// i2cw_pkg: shared types and constants for the I2C master write sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2cw_pkg;

  localparam int ActW           = 2;
  localparam int DataW          = 8;
  localparam int BitsPerByteDef = 8;
  localparam int QueueDepthDef  = 2;

  // Bus operation codes; the fourth code carries no operation.
  typedef enum logic [ActW-1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_START,
    ENG_STOP,
    ENG_DATA,
    ENG_ACK
  } eng_state_e;

  // One queued bus operation.
  typedef struct packed {
    act_e             act;
    logic [DataW-1:0] data;
  } cmd_t;

endpackage

>>> design/i2c_master_write_sequencer.sv
// i2c_master_write_sequencer: top level of the write-only I2C line sequencer.
// Depends on i2cw_pkg, i2cw_front, i2cw_queue and i2cw_engine.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, action_i,          | to block
//           | data_byte_i                               |
//   out     | out_valid_o, out_ready_i, scl_released_o,  | from block
//           | sda_released_o, hold_after_o, last_o      |
//
// The line engine emits one line state per cycle unless out_ready_i stalls
// it; a byte write steps through its data bits, then the acknowledge.
// The next queued operation loads on the cycle its predecessor emits its last
// state, so operations run back to back; the engine sets the rate.
// Unused action codes are accepted and dropped with no output.
// Reset releases both lines (levels remembered as 1) and empties the queue.
// A stall on out_ready_i freezes the engine; the QueueDepth-entry queue keeps
// accepting operations until it fills.
`timescale 1ns / 1ps

module i2c_master_write_sequencer #(
  parameter int BitsPerByte = i2cw_pkg::BitsPerByteDef,
  parameter int QueueDepth  = i2cw_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [i2cw_pkg::ActW-1:0]  action_i,
  input  logic [i2cw_pkg::DataW-1:0] data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       scl_released_o,
  output logic                       sda_released_o,
  output logic                       hold_after_o,
  output logic                       last_o
);
  import i2cw_pkg::*;

  // Front to queue: filtered operations.
  cmd_t push_cmd;
  logic push, q_full;
  // Queue to engine.
  cmd_t head_cmd;
  logic head_valid, pop;

  i2cw_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_cmd_o     (push_cmd)
  );

  i2cw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // Line engine: owns the SCL/SDA level memory and the output register.
  i2cw_engine #(
    .BitsPerByte (BitsPerByte)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (head_valid),
    .q_cmd_i        (head_cmd),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scl_released_o (scl_released_o),
    .sda_released_o (sda_released_o),
    .hold_after_o   (hold_after_o),
    .last_o         (last_o)
  );

endmodule

>>> design/i2cw_front.sv
// i2cw_front: accepts input transactions, drops unused operation codes and
// packs the rest into queue entries. Depends on i2cw_pkg.
`timescale 1ns / 1ps

module i2cw_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [i2cw_pkg::ActW-1:0] action_i,
  input  logic [i2cw_pkg::DataW-1:0] data_byte_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output i2cw_pkg::cmd_t            q_cmd_o
);
  import i2cw_pkg::*;

  logic act_known;

  always_comb begin
    unique case (action_i)
      ACT_START, ACT_STOP, ACT_WRITE: act_known = 1'b1;
      default:                        act_known = 1'b0;
    endcase
  end

  // Unknown codes are taken and discarded, so they never wait on the queue.
  assign in_ready_o   = ~q_full_i | ~act_known;
  assign q_push_o     = in_valid_i & ~q_full_i & act_known;
  assign q_cmd_o.act  = act_e'(action_i);
  assign q_cmd_o.data = data_byte_i;

endmodule

>>> design/i2cw_queue.sv
// i2cw_queue: small register FIFO of bus operations between the front and
// the line engine. Depends on i2cw_pkg.
`timescale 1ns / 1ps

module i2cw_queue #(
  parameter int Depth = i2cw_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  i2cw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output i2cw_pkg::cmd_t cmd_o
);
  import i2cw_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/i2cw_engine.sv
// i2cw_engine: steps SCL/SDA line states of a bus operation into an output
// register, one per cycle unless the output stalls. Depends on i2cw_pkg.
`timescale 1ns / 1ps

module i2cw_engine #(
  parameter int BitsPerByte = i2cw_pkg::BitsPerByteDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  i2cw_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           scl_released_o,
  output logic           sda_released_o,
  output logic           hold_after_o,
  output logic           last_o
);
  import i2cw_pkg::*;

  localparam int Bits = (BitsPerByte > 8) ? 8 : ((BitsPerByte < 1) ? 1 : BitsPerByte);
  localparam int CntW = $clog2(Bits + 1);
  localparam logic [CntW-1:0] BitLast = CntW'(Bits - 1);

  eng_state_e       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [CntW-1:0]  bitcnt_q, bitcnt_d;
  logic [DataW-1:0] shreg_q, shreg_d;
  logic             scl_q, sda_q;
  logic             out_valid_q, scl_out_q, sda_out_q, hold_out_q, last_out_q;
  logic             emit, load;
  logic             res_scl, res_sda, res_hold, res_last;
  logic             bit_val;

  assign emit    = (state_q != ENG_IDLE) & (~out_valid_q | out_ready_i);
  assign load    = q_valid_i & ((state_q == ENG_IDLE) | (emit & res_last));
  assign q_pop_o = load;
  assign bit_val = shreg_q[DataW-1];

  // Line state for the current step.
  always_comb begin
    res_scl  = 1'b1;
    res_sda  = 1'b1;
    res_hold = 1'b0;
    res_last = 1'b0;
    unique case (state_q)
      ENG_IDLE: begin
      end
      ENG_START: begin
        unique case (phase_q)
          2'd0:    begin res_scl = 1'b1; res_sda = sda_q; end
          2'd1:    begin res_scl = 1'b1; res_sda = 1'b1; end
          2'd2:    begin res_scl = 1'b1; res_sda = 1'b0; res_hold = 1'b1; end
          default: begin
            res_scl = 1'b0; res_sda = 1'b0; res_hold = 1'b1; res_last = 1'b1;
          end
        endcase
      end
      ENG_STOP: begin
        res_hold = 1'b1;
        unique case (phase_q)
          2'd0:    begin res_scl = scl_q; res_sda = 1'b0; end
          2'd1:    begin res_scl = 1'b1; res_sda = 1'b0; end
          default: begin res_scl = 1'b1; res_sda = 1'b1; res_last = 1'b1; end
        endcase
      end
      ENG_DATA: begin
        res_sda = bit_val;
        unique case (phase_q)
          2'd0:    begin res_scl = scl_q; res_hold = 1'b1; end
          2'd1:    begin res_scl = 1'b1; res_hold = 1'b1; end
          default: begin res_scl = 1'b0; res_hold = 1'b0; end
        endcase
      end
      ENG_ACK: begin
        res_sda  = 1'b1;
        res_hold = 1'b1;
        unique case (phase_q)
          2'd0:    res_scl = scl_q;
          2'd1:    res_scl = 1'b1;
          default: begin res_scl = 1'b0; res_last = 1'b1; end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequencing and command load.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    bitcnt_d = bitcnt_q;
    shreg_d  = shreg_q;
    if (emit) begin
      if (res_last) begin
        state_d = ENG_IDLE;
        phase_d = '0;
      end else if (state_q == ENG_DATA && phase_q == 2'd2) begin
        phase_d = '0;
        shreg_d = {shreg_q[DataW-2:0], 1'b0};
        if (bitcnt_q == BitLast) begin
          state_d = ENG_ACK;
        end else begin
          bitcnt_d = bitcnt_q + 1'b1;
        end
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
    if (load) begin
      phase_d  = '0;
      bitcnt_d = '0;
      shreg_d  = q_cmd_i.data;
      unique case (q_cmd_i.act)
        ACT_START: state_d = ENG_START;
        ACT_STOP:  state_d = ENG_STOP;
        ACT_WRITE: state_d = ENG_DATA;
        default:   state_d = ENG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      phase_q     <= '0;
      bitcnt_q    <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      if (emit) begin
        scl_q       <= res_scl;
        sda_q       <= res_sda;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    if (emit) begin
      scl_out_q  <= res_scl;
      sda_out_q  <= res_sda;
      hold_out_q <= res_hold;
      last_out_q <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_released_o = scl_out_q;
  assign sda_released_o = sda_out_q;
  assign hold_after_o   = hold_out_q;
  assign last_o         = last_out_q;

`ifndef ASSERT_OFF
  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res_last |-> res_hold)
    else $error("final line state without hold");

  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ENG_IDLE |-> phase_q == 2'd0)
    else $error("phase counter running while idle");

  a_bitcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ENG_DATA |-> bitcnt_q <= BitLast)
    else $error("bit counter past byte length");

  a_line_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> scl_q == scl_released_o && sda_q == sda_released_o)
    else $error("tracked line levels differ from emitted state");

  a_no_hold_scl_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !res_hold && !res_scl |-> state_q == ENG_DATA)
    else $error("unheld SCL low outside a data bit");
`endif

endmodule
